### design/nta_pkg.sv
// Package for the number to ASCII formatter.
// Holds character constants, the sequencer state type and the cell control struct.
// No dependencies.
`default_nettype none
package nta_pkg;

  localparam int unsigned ValueWidth = 16;
  localparam int unsigned CharWidth  = 8;
  localparam int unsigned DigitWidth = 4;
  localparam int unsigned NumCells   = 5;
  localparam int unsigned CountWidth = $clog2(ValueWidth);
  localparam int unsigned PosWidth   = 3;

  localparam logic [CharWidth-1:0] CharZero  = 8'h30;
  localparam logic [CharWidth-1:0] CharUpperA = 8'h41;
  localparam logic [CharWidth-1:0] CharX     = 8'h78;

  localparam logic [DigitWidth-1:0] DecRadix = 4'd10;
  localparam logic [DigitWidth-1:0] AdjLimit = 4'd5;
  localparam logic [DigitWidth-1:0] AdjAdd   = 4'd3;

  localparam logic MODE_DEC = 1'b0;
  localparam logic MODE_HEX = 1'b1;

  localparam logic [PosWidth-1:0] POS_HEX_SHORT = 3'd3;
  localparam logic [PosWidth-1:0] POS_HEX_LONG  = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_FIND,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

  function automatic logic [CharWidth-1:0] hex_char(input logic [DigitWidth-1:0] nib);
    logic [CharWidth-1:0] c;
    if (nib < DecRadix) begin
      c = CharZero + {4'd0, nib};
    end else begin
      c = CharUpperA + {4'd0, nib - DecRadix};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### design/nta_bcd_cell.sv
// One decimal digit cell of the shift-add-3 conversion chain.
// Depends on nta_pkg.
`default_nettype none
module nta_bcd_cell (
  input  wire logic                         clk,
  input  wire nta_pkg::cell_ctrl_t          ctrl,
  input  wire logic                         shift_in,
  output logic [nta_pkg::DigitWidth-1:0]    digit,
  output logic                              shift_out
);

  logic [nta_pkg::DigitWidth-1:0] digit_r;
  logic [nta_pkg::DigitWidth-1:0] digit_nxt;
  logic [nta_pkg::DigitWidth-1:0] adj;

  always_comb begin
    if (digit_r >= nta_pkg::AdjLimit) begin
      adj = digit_r + nta_pkg::AdjAdd;
    end else begin
      adj = digit_r;
    end
    shift_out = adj[nta_pkg::DigitWidth-1];
    if (ctrl.clear) begin
      digit_nxt = '0;
    end else if (ctrl.shift) begin
      digit_nxt = {adj[nta_pkg::DigitWidth-2:0], shift_in};
    end else begin
      digit_nxt = digit_r;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  assign digit = digit_r;

endmodule
`default_nettype wire

### design/number_to_ascii_formatter_unit.sv
// Top level of the number to ASCII formatter: sequencer, BCD cell chain, output register.
// Depends on nta_pkg and nta_bcd_cell.
//
// Usage:
//   Input channel in_valid/in_stall carries in_value (16 bit) and in_mode
//   (0 decimal, 1 hex with 0x prefix). Output channel out_valid/out_stall
//   carries one ASCII character per transaction in out_char_code, with
//   out_last high on the final character of a number.
//   Decimal: the value shifts through a chain of five BCD digit cells, one
//   bit per cycle; the FIND state then locates the leading digit.
//   Hex: conversion is skipped, the FIND state sets up the character count.
//   Characters then leave at one per cycle through the output register
//   while the output is not stalled. Decimal gives 1..5 digits, hex gives
//   4 or 6 characters including the prefix. One item is processed at a time;
//   a new item is accepted while the final character still waits in the
//   output register.
//   Reset clears the sequencer and the output valid flag.
//   A stall on the output holds the current character and pauses emission.
`default_nettype none
module number_to_ascii_formatter_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [nta_pkg::ValueWidth-1:0]  in_value,
  input  wire logic                            in_mode,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [nta_pkg::CharWidth-1:0]        out_char_code,
  output logic                                 out_last
);

  nta_pkg::state_t state_r, state_nxt;

  logic [nta_pkg::ValueWidth-1:0] value_r, value_nxt;
  logic                           mode_r, mode_nxt;
  logic [nta_pkg::CountWidth-1:0] cnt_r, cnt_nxt;
  logic [nta_pkg::PosWidth-1:0]   pos_r, pos_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [nta_pkg::CharWidth-1:0]  out_char_r, out_char_nxt;
  logic                           out_last_r, out_last_nxt;

  logic                           in_take;
  logic                           emit_go;
  logic [nta_pkg::CharWidth-1:0]  cur_char;
  logic [nta_pkg::DigitWidth-1:0] cur_digit;
  logic [nta_pkg::DigitWidth-1:0] cur_nib;
  logic [nta_pkg::PosWidth-1:0]   top_pos;
  nta_pkg::cell_ctrl_t            cell_ctrl;

  logic [nta_pkg::DigitWidth-1:0] digit [nta_pkg::NumCells];
  logic [nta_pkg::NumCells:0]     chain;

  function automatic logic [nta_pkg::PosWidth-1:0] top_hex(
    input logic [nta_pkg::ValueWidth-1:0] v
  );
    return (v[15:8] != '0) ? nta_pkg::POS_HEX_LONG : nta_pkg::POS_HEX_SHORT;
  endfunction

  assign in_stall = (state_r != nta_pkg::ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign emit_go  = (state_r == nta_pkg::ST_EMIT) && (!out_valid_r || !out_stall);

  assign cell_ctrl.clear = in_take;
  assign cell_ctrl.shift = (state_r == nta_pkg::ST_CONV);

  assign chain[0] = value_r[nta_pkg::ValueWidth-1];

  for (genvar g = 0; g < nta_pkg::NumCells; g++) begin : g_cell
    nta_bcd_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .shift_in  (chain[g]),
      .digit     (digit[g]),
      .shift_out (chain[g+1])
    );
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nta_pkg::ST_IDLE: begin
        if (in_take) begin
          state_nxt = (in_mode == nta_pkg::MODE_HEX) ? nta_pkg::ST_FIND : nta_pkg::ST_CONV;
        end
      end
      nta_pkg::ST_CONV: begin
        if (cnt_r == '0) begin
          state_nxt = nta_pkg::ST_FIND;
        end
      end
      nta_pkg::ST_FIND: begin
        state_nxt = nta_pkg::ST_EMIT;
      end
      nta_pkg::ST_EMIT: begin
        if (emit_go && pos_r == '0) begin
          state_nxt = nta_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = nta_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (digit[4] != '0) begin
      top_pos = 3'd4;
    end else if (digit[3] != '0) begin
      top_pos = 3'd3;
    end else if (digit[2] != '0) begin
      top_pos = 3'd2;
    end else if (digit[1] != '0) begin
      top_pos = 3'd1;
    end else begin
      top_pos = 3'd0;
    end

    case (pos_r)
      3'd0:    cur_digit = digit[0];
      3'd1:    cur_digit = digit[1];
      3'd2:    cur_digit = digit[2];
      3'd3:    cur_digit = digit[3];
      3'd4:    cur_digit = digit[4];
      default: cur_digit = '0;
    endcase

    case (pos_r)
      3'd0:    cur_nib = value_r[3:0];
      3'd1:    cur_nib = value_r[7:4];
      3'd2:    cur_nib = value_r[11:8];
      3'd3:    cur_nib = value_r[15:12];
      default: cur_nib = '0;
    endcase

    if (mode_r == nta_pkg::MODE_HEX) begin
      if (pos_r == top_hex(value_r)) begin
        cur_char = nta_pkg::CharZero;
      end else if (pos_r == top_hex(value_r) - 3'd1) begin
        cur_char = nta_pkg::CharX;
      end else begin
        cur_char = nta_pkg::hex_char(cur_nib);
      end
    end else begin
      cur_char = nta_pkg::CharZero + {4'd0, cur_digit};
    end
  end

  always_comb begin
    value_nxt     = value_r;
    mode_nxt      = mode_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      nta_pkg::ST_IDLE: begin
        if (in_take) begin
          value_nxt = in_value;
          mode_nxt  = in_mode;
          cnt_nxt   = '1;
        end
      end
      nta_pkg::ST_CONV: begin
        value_nxt = {value_r[nta_pkg::ValueWidth-2:0], 1'b0};
        cnt_nxt   = cnt_r - 1'b1;
      end
      nta_pkg::ST_FIND: begin
        pos_nxt = (mode_r == nta_pkg::MODE_HEX) ? top_hex(value_r) : top_pos;
      end
      nta_pkg::ST_EMIT: begin
        if (emit_go) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = cur_char;
          out_last_nxt  = (pos_r == '0);
          pos_nxt       = pos_r - 1'b1;
        end
      end
      default: begin
        pos_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nta_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r    <= value_nxt;
    mode_r     <= mode_nxt;
    cnt_r      <= cnt_nxt;
    pos_r      <= pos_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;

endmodule
`default_nettype wire

### design/nta_checker.sv
// Port-level checks for the number to ASCII formatter, bound to the top level.
// Depends on nta_pkg and number_to_ascii_formatter_unit.
`default_nettype none
module nta_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_stall,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic [nta_pkg::CharWidth-1:0]  out_char_code,
  input wire logic                           out_last
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("output valid or input stall after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char_code) && $stable(out_last))
    else $error("stalled output transaction changed");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accepting a transaction");

  a_text_open_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> in_stall)
    else $error("input accepted before text of previous item finished");

endmodule

bind number_to_ascii_formatter_unit nta_checker u_nta_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_char_code (out_char_code),
  .out_last      (out_last)
);
`default_nettype wire
